@@ design/pks_pkg.sv @@
package pks_pkg;

  localparam int unsigned KEY_CODES = 256;
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned CODE_SPACE = 1 << KEY_W;
  localparam int unsigned CNT_W     = KEY_W + 1;
  localparam int unsigned INFO_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [REQ_W-1:0] {
    REQ_PRESS   = 3'd0,
    REQ_RELEASE = 3'd1,
    REQ_CLEAR   = 3'd2,
    REQ_READ    = 3'd3,
    REQ_TEST    = 3'd4
  } req_e;

  typedef struct packed {
    logic accept;
    logic apply;
    logic load;
  } pks_cmd_t;

  typedef struct packed {
    logic out_free;
  } pks_status_t;

endpackage

@@ design/pks_ctrl.sv @@
module pks_ctrl
  import pks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pks_status_t status_i,
  output pks_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.apply  = 1'b0;
    cmd_o.load   = 1'b0;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/pks_datapath.sv @@
module pks_datapath
  import pks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pks_cmd_t              cmd_i,
  output pks_status_t           status_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [KEY_W-1:0]      key_code_i,
  input  logic [INFO_W-1:0]     key_info_i,
  input  logic [KEY_W-1:0]      slot_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  logic [KEY_W-1:0]  list_mem [CODE_SPACE];
  logic [KEY_W-1:0]  pos_mem  [CODE_SPACE];
  logic [INFO_W-1:0] info_mem [CODE_SPACE];

  logic [REQ_W-1:0]      req_q;
  logic [KEY_W-1:0]      code_q;
  logic [INFO_W-1:0]     info_q;
  logic [KEY_W-1:0]      sidx_q;
  logic [KEY_W-1:0]      list_rd_q;
  logic [KEY_W-1:0]      pos_rd_q;
  logic [INFO_W-1:0]     info_rd_q;
  logic [CODE_SPACE-1:0] held_bits_q, held_bits_d;
  logic [CNT_W-1:0]      total_q, total_d;
  logic                  changed_q, changed_d;
  logic                  svalid_q;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic [CNT_W-1:0] total_m1;
  logic [KEY_W-1:0] list_raddr;
  logic             code_ok;
  logic             held_now;
  logic             press_do;
  logic             rel_do;
  logic             is_held;
  logic [KEY_W-1:0]  slot_key;
  logic [INFO_W-1:0] slot_info;

  assign total_m1   = total_q - CNT_W'(1);
  assign list_raddr = (req_type_i == REQ_RELEASE) ? total_m1[KEY_W-1:0] : slot_index_i;
  assign code_ok    = {1'b0, code_q} < CNT_W'(KEY_CODES);
  assign held_now   = held_bits_q[code_q];
  assign press_do   = (req_q == REQ_PRESS) && code_ok && !held_now
                      && (total_q < CNT_W'(KEY_CODES));
  assign rel_do     = (req_q == REQ_RELEASE) && code_ok && held_now
                      && (total_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q     <= req_type_i;
      code_q    <= key_code_i;
      info_q    <= key_info_i;
      sidx_q    <= slot_index_i;
      list_rd_q <= list_mem[list_raddr];
      pos_rd_q  <= pos_mem[key_code_i];
    end
    if (cmd_i.apply) begin
      info_rd_q <= info_mem[list_rd_q];
      svalid_q  <= (req_q == REQ_READ) && ({1'b0, sidx_q} < total_q);
      if (press_do) begin
        list_mem[total_q[KEY_W-1:0]] <= code_q;
        pos_mem[code_q]              <= total_q[KEY_W-1:0];
        info_mem[code_q]             <= info_q;
      end else if (rel_do) begin
        list_mem[pos_rd_q]  <= list_rd_q;
        pos_mem[list_rd_q]  <= pos_rd_q;
        info_mem[code_q]    <= '0;
      end
    end
  end

  always_comb begin
    held_bits_d = held_bits_q;
    total_d     = total_q;
    changed_d   = changed_q;
    if (cmd_i.apply) begin
      changed_d = 1'b0;
      case (req_q)
        REQ_PRESS: begin
          if (press_do) begin
            held_bits_d[code_q] = 1'b1;
            total_d             = total_q + CNT_W'(1);
            changed_d           = 1'b1;
          end
        end
        REQ_RELEASE: begin
          if (rel_do) begin
            held_bits_d[code_q] = 1'b0;
            total_d             = total_m1;
            changed_d           = 1'b1;
          end
        end
        REQ_CLEAR: begin
          held_bits_d = '0;
          total_d     = '0;
          changed_d   = (total_q != '0);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bits_q <= '0;
      total_q     <= '0;
      changed_q   <= 1'b0;
    end else begin
      held_bits_q <= held_bits_d;
      total_q     <= total_d;
      changed_q   <= changed_d;
    end
  end

  assign is_held   = code_ok && held_now;
  assign slot_key  = svalid_q ? list_rd_q : '0;
  assign slot_info = svalid_q ? info_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {4'b0, total_q, slot_info, slot_key, svalid_q, is_held, changed_q};
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(KEY_CODES))
    else $error("held count above key range");

  a_total_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.apply |=> $stable(total_q))
    else $error("held count moved outside apply");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && req_q == REQ_CLEAR) |=> (total_q == '0) && (held_bits_q == '0))
    else $error("clear left keys held");

  a_press_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.apply && press_do) |=> held_bits_q[code_q]
      && (total_q == $past(total_q) + CNT_W'(1)))
    else $error("press did not register key");

endmodule

@@ design/pressed_key_sparse_set.sv @@
// Requests are handled one at a time: memory read, then write or dependent read, then
// result load into the output register, which waits while that register is still full;
// the next request is taken while a result waits downstream.
// Reset: presence flops, held count and output valid clear at once; the list, slot
// map and info stores are undefined until written and get no clearing pass.
module pressed_key_sparse_set
  import pks_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // key_code[7:0], key_info[39:8], slot_index[47:40]
  input  logic [REQ_W-1:0]      s_axis_tuser,  // req_type[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // changed[0], is_held[1], slot_valid[2],
                                               // slot_key[10:3], slot_info[42:11],
                                               // held_count[51:43], zero[55:52]
);

  pks_cmd_t    cmd;
  pks_status_t status;

  pks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pks_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (s_axis_tuser),
    .key_code_i   (s_axis_tdata[7:0]),
    .key_info_i   (s_axis_tdata[39:8]),
    .slot_index_i (s_axis_tdata[47:40]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
